// ----- rtl/core/route_table_merge_unit_defines.svh -----
// ---------------------------------------------------------------------------
// route table merge unit assertion macros
// shared assertion wrappers for the checker of the route table merge unit
// ---------------------------------------------------------------------------
`ifndef ROUTE_TABLE_MERGE_UNIT_DEFINES_SVH
`define ROUTE_TABLE_MERGE_UNIT_DEFINES_SVH

// clocked assertion, masked while reset is active
`define RTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RTM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rtm_pkg.sv -----
// ---------------------------------------------------------------------------
// route table merge package
// types, codes and helper functions shared by the route table merge unit
// ---------------------------------------------------------------------------
package rtm_pkg;

	localparam int TBL_DEPTH_DEF = 128;

	localparam int CALL_W = 48;
	localparam int SSID_W = 4;
	localparam int RTT_W  = 20;
	localparam int PORT_W = 8;
	localparam int STAT_W = 3;
	localparam int OCNT_W = 8;

	localparam logic [RTT_W-1:0] RTT_INF_RST = 20'd60000;

	// apb register map
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_RTT_INF = 2'd0;

	// item modes
	localparam logic MODE_MERGE    = 1'b0;
	localparam logic MODE_WITHDRAW = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_MATCHED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_WD_DONE  = 3'd4;

	typedef struct packed {
		logic              mode;
		logic [CALL_W-1:0] callsign;
		logic [SSID_W-1:0] ssid_low;
		logic [SSID_W-1:0] ssid_high;
		logic [RTT_W-1:0]  route_rtt;
		logic [PORT_W-1:0] neighbor_port;
	} item_t;

	typedef struct packed {
		logic [CALL_W-1:0] callsign;
		logic [SSID_W-1:0] ssid_low;
		logic [SSID_W-1:0] ssid_high;
		logic [RTT_W-1:0]  rtt;
		logic [PORT_W-1:0] port;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;  // capture item, restart walk
		logic rd;    // read entry at walk index
		logic chk;   // evaluate entry read last cycle
		logic tail;  // end of walk: append, full or withdraw done
		logic pub;   // copy result into output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;  // walk index reached entry count
		logic hit;   // merge item matches entry read last cycle
	} dp_sts_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	// case-insensitive compare, top byte first, ends equal at a shared zero
	function automatic logic calls_equal(input logic [CALL_W-1:0] a,
			input logic [CALL_W-1:0] b);
		logic       eq;
		logic       done;
		logic [7:0] ca;
		logic [7:0] cb;
		eq   = 1'b1;
		done = 1'b0;
		for (int i = 5; i >= 0; i--) begin
			ca = fold_byte(a[8*i +: 8]);
			cb = fold_byte(b[8*i +: 8]);
			if (!done) begin
				if (ca != cb) begin
					eq   = 1'b0;
					done = 1'b1;
				end else if (ca == 8'h00) begin
					done = 1'b1;
				end
			end
		end
		return eq;
	endfunction

endpackage

// ----- rtl/core/rtm_chan_if.sv -----
// ---------------------------------------------------------------------------
// route table merge channels
// valid/ready channels for item beats and result beats
// ---------------------------------------------------------------------------
interface rtm_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [47:0] callsign;
	logic [3:0]  ssid_low;
	logic [3:0]  ssid_high;
	logic [19:0] route_rtt;
	logic [7:0]  neighbor_port;

	modport source (output valid, mode, callsign, ssid_low, ssid_high, route_rtt,
		neighbor_port, input ready);
	modport sink (input valid, mode, callsign, ssid_low, ssid_high, route_rtt,
		neighbor_port, output ready);
endinterface

interface rtm_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] withdrawn_count;
	logic [7:0] entry_total;

	modport source (output valid, status, withdrawn_count, entry_total, input ready);
	modport sink (input valid, status, withdrawn_count, entry_total, output ready);
endinterface

// ----- rtl/core/route_table_merge_unit.sv -----
// ---------------------------------------------------------------------------
// route table merge unit
// destination route table with merge and port withdraw, one result per item
// ---------------------------------------------------------------------------
// usage
// - item channel: valid/ready, one beat per merge or withdraw request
// - result channel: valid/ready, one beat per item carrying status,
//   withdrawn count and entry total
// - apb port: register 0 at byte 0 holds the unreachable round-trip time
// - a beat is accepted when valid and ready are both high at a clock edge
// - an item walks the table one entry per cycle through the single
//   read port of the entry memory; a merge stops at its first match
// - one item at a time: the next item is taken only once the previous
//   result has been moved into the output register
// - reset clears the entry count and loads the default infinity value;
//   entry memory contents are left as they are, unused slots never read
// - a stalled result beat sits in the output register while the next item
//   is taken and walked; its result waits until the register frees up
// ---------------------------------------------------------------------------
module route_table_merge_unit import rtm_pkg::*; #(
	parameter int TABLE_DEPTH = TBL_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	rtm_item_if.sink            item,
	rtm_result_if.source        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	ctl_cmd_t         cmd;
	dp_sts_t          sts;
	item_t            item_pl;
	logic [RTT_W-1:0] rtt_inf;

	// pack the item beat for the datapath
	assign item_pl.mode          = item.mode;
	assign item_pl.callsign      = item.callsign;
	assign item_pl.ssid_low      = item.ssid_low;
	assign item_pl.ssid_high     = item.ssid_high;
	assign item_pl.route_rtt     = item.route_rtt;
	assign item_pl.neighbor_port = item.neighbor_port;

	// configuration registers
	rtm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rtt_inf (rtt_inf)
	);

	// walk sequencer and handshakes
	rtm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// entry memory, compare and result registers
	rtm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.item            (item_pl),
		.rtt_inf         (rtt_inf),
		.status          (result.status),
		.withdrawn_count (result.withdrawn_count),
		.entry_total     (result.entry_total)
	);

endmodule

// ----- rtl/core/rtm_regs.sv -----
// ---------------------------------------------------------------------------
// route table merge registers
// apb register file holding the unreachable round-trip time
// ---------------------------------------------------------------------------
module rtm_regs import rtm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [RTT_W-1:0]  rtt_inf
);

	logic [RTT_W-1:0] rtt_inf_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_RTT_INF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtt_inf_q <= RTT_INF_RST;
		end else if (wr_en) begin
			rtt_inf_q <= pwdata[RTT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_RTT_INF) begin
			prdata = APB_DW'(rtt_inf_q);
		end
	end

	assign rtt_inf = rtt_inf_q;

endmodule

// ----- rtl/core/rtm_ctrl.sv -----
// ---------------------------------------------------------------------------
// route table merge controller
// sequences the table walk and the item and result handshakes
// ---------------------------------------------------------------------------
module rtm_ctrl import rtm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t cmd,
	input  dp_sts_t  sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       pend_q;
	logic       pend_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pend_d  = pend_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pend_d   = 1'b0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.chk = pend_q;
				if (pend_q && sts.hit) begin
					// first match ends a merge walk
					pend_d  = 1'b0;
					state_d = S_FIN;
				end else if (!sts.last) begin
					cmd.rd = 1'b1;
					pend_d = 1'b1;
				end else if (pend_q) begin
					pend_d = 1'b0;
				end else begin
					cmd.tail = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.pub = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				pend_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (cmd.pub) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/rtm_datapath.sv -----
// ---------------------------------------------------------------------------
// route table merge datapath
// entry memory, walk index, entry compare and result registers
// ---------------------------------------------------------------------------
module rtm_datapath import rtm_pkg::*; #(
	parameter int TABLE_DEPTH = TBL_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	output dp_sts_t           sts,
	input  item_t             item,
	input  logic [RTT_W-1:0]  rtt_inf,
	output logic [STAT_W-1:0] status,
	output logic [OCNT_W-1:0] withdrawn_count,
	output logic [OCNT_W-1:0] entry_total
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	entry_t mem [TABLE_DEPTH];

	item_t             item_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  wd_cnt_q;
	logic [STAT_W-1:0] res_stat_q;
	entry_t            rdata_s1;
	logic [IDX_W-1:0]  raddr_s1;

	logic [STAT_W-1:0] out_stat_q;
	logic [OCNT_W-1:0] out_cnt_q;
	logic [OCNT_W-1:0] out_total_q;

	logic             key_eq;
	logic             port_eq;
	logic             take_new;
	logic             has_room;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;

	assign key_eq   = calls_equal(rdata_s1.callsign, item_q.callsign) &&
		(rdata_s1.ssid_low == item_q.ssid_low) && (rdata_s1.ssid_high == item_q.ssid_high);
	assign port_eq  = (rdata_s1.port == item_q.neighbor_port);
	assign take_new = (item_q.route_rtt < rdata_s1.rtt) || port_eq;
	assign has_room = (used_q < CNT_W'(TABLE_DEPTH));

	assign sts.last = (scan_q == used_q);
	assign sts.hit  = (item_q.mode == MODE_MERGE) && key_eq;

	// single write port: entry update, withdraw mark or append
	always_comb begin
		we    = 1'b0;
		waddr = raddr_s1;
		wdata = rdata_s1;
		if (cmd.chk) begin
			if (item_q.mode == MODE_WITHDRAW) begin
				we        = port_eq;
				wdata.rtt = rtt_inf;
			end else begin
				we         = key_eq && take_new;
				wdata.rtt  = item_q.route_rtt;
				wdata.port = item_q.neighbor_port;
			end
		end else if (cmd.tail && item_q.mode == MODE_MERGE) begin
			we              = has_room;
			waddr           = used_q[IDX_W-1:0];
			wdata.callsign  = item_q.callsign;
			wdata.ssid_low  = item_q.ssid_low;
			wdata.ssid_high = item_q.ssid_high;
			wdata.rtt       = item_q.route_rtt;
			wdata.port      = item_q.neighbor_port;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[scan_q[IDX_W-1:0]];
			raddr_s1 <= scan_q[IDX_W-1:0];
		end
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.pub) begin
			out_stat_q  <= res_stat_q;
			out_cnt_q   <= OCNT_W'(wd_cnt_q);
			out_total_q <= OCNT_W'(used_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			scan_q     <= '0;
			wd_cnt_q   <= '0;
			res_stat_q <= ST_FULL;
		end else begin
			if (cmd.load) begin
				scan_q     <= '0;
				wd_cnt_q   <= '0;
				res_stat_q <= ST_FULL;
			end else if (cmd.rd) begin
				scan_q <= CNT_W'(scan_q + 1'b1);
			end
			if (cmd.chk) begin
				if (item_q.mode == MODE_WITHDRAW) begin
					if (port_eq) begin
						wd_cnt_q <= CNT_W'(wd_cnt_q + 1'b1);
					end
				end else if (key_eq) begin
					res_stat_q <= take_new ? ST_UPDATED : ST_MATCHED;
				end
			end
			if (cmd.tail) begin
				if (item_q.mode == MODE_WITHDRAW) begin
					res_stat_q <= ST_WD_DONE;
				end else if (has_room) begin
					res_stat_q <= ST_INSERTED;
					used_q     <= CNT_W'(used_q + 1'b1);
				end else begin
					res_stat_q <= ST_FULL;
				end
			end
		end
	end

	assign status          = out_stat_q;
	assign withdrawn_count = out_cnt_q;
	assign entry_total     = out_total_q;

endmodule

// ----- rtl/core/rtm_checker.sv -----
// ---------------------------------------------------------------------------
// route table merge checker
// port-level assertions bound to the route table merge unit
// ---------------------------------------------------------------------------
`include "route_table_merge_unit_defines.svh"

module rtm_checker import rtm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic [OCNT_W-1:0] withdrawn_count,
	input logic [OCNT_W-1:0] entry_total,
	input logic              pready
);

	// a stalled result beat stays offered
	`RTM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

	// only withdraw results carry a count
	`RTM_ASSERT(a_cnt_merge, out_valid && (status != ST_WD_DONE) |-> withdrawn_count == '0, "nonzero count on merge result")

	// an insert always leaves at least one entry
	`RTM_ASSERT(a_ins_total, out_valid && (status == ST_INSERTED) |-> entry_total != '0, "insert with empty table")

	// status code within the defined set
	`RTM_ASSERT(a_stat_code, out_valid |-> status <= ST_WD_DONE, "undefined status code")

	// register port never waits
	`RTM_ASSERT_ALWAYS(a_pready, pready, "apb pready low")

endmodule

bind route_table_merge_unit rtm_checker u_rtm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.status          (result.status),
	.withdrawn_count (result.withdrawn_count),
	.entry_total     (result.entry_total),
	.pready          (pready)
);
